/* rtl/paclip_pkg.sv */
// Package for the primitive assembly and trivial reject block.
// Holds shared widths, configuration codes and the structs passed between modules.
// No dependencies.
`timescale 1ns / 1ps

package paclip_pkg;

  // Fixed field widths.
  localparam int IDX_W      = 11;
  localparam int CODE_W     = 5;
  localparam int XY_CLIP_W  = 4;
  localparam int NEAR_BIT   = 4;
  localparam int IN_COORD_W = 16;
  localparam int KIND_W     = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 3;

  // Defaults for the top-level parameters.
  localparam int DEF_MAX_VERTICES = 2048;
  localparam int DEF_COORD_BITS   = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_PRIMITIVE_KIND = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CULL_NONE      = 1'd1;

  // Primitive kinds.
  localparam logic [KIND_W-1:0] KIND_TRIANGLES  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_FAN        = 3'd1;
  localparam logic [KIND_W-1:0] KIND_QUADS      = 3'd2;
  localparam logic [KIND_W-1:0] KIND_POLYGON    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_LINES      = 3'd4;
  localparam logic [KIND_W-1:0] KIND_STRIP      = 3'd5;
  localparam logic [KIND_W-1:0] KIND_QUAD_STRIP = 3'd6;

  // Index and clip summary of one assembled triangle.
  typedef struct packed {
    logic [IDX_W-1:0] idx_a;
    logic [IDX_W-1:0] idx_b;
    logic [IDX_W-1:0] idx_c;
    logic             needs_clip;
  } prim_ctrl_t;

  // Up to two surviving triangles produced by one vertex.
  typedef struct packed {
    logic [1:0]            valid;
    prim_ctrl_t [1:0]      prim;
  } job_ctrl_t;

  // Status of the emit stage seen by the top level.
  typedef struct packed {
    logic [1:0] pending;
    logic       ready;
  } emit_stat_t;

endpackage

/* rtl/paclip_assembler.sv */
// Vertex history, batch counter and triangle assembly with trivial reject.
// Depends on paclip_pkg.
`timescale 1ns / 1ps

module paclip_assembler #(
  parameter int MAX_VERTICES = paclip_pkg::DEF_MAX_VERTICES,
  parameter int COORD_BITS   = paclip_pkg::DEF_COORD_BITS
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   accept,
  input  logic signed [paclip_pkg::IN_COORD_W-1:0] screen_x,
  input  logic signed [paclip_pkg::IN_COORD_W-1:0] screen_y,
  input  logic [paclip_pkg::CODE_W-1:0]          clip_code,
  input  logic                                   batch_end,
  input  logic [paclip_pkg::KIND_W-1:0]          kind,
  output paclip_pkg::job_ctrl_t                  job,
  output logic [1:0][2:0][COORD_BITS-1:0]        job_x,
  output logic [1:0][2:0][COORD_BITS-1:0]        job_y
);

  localparam int CNT_W = $clog2(MAX_VERTICES + 1);
  localparam int NSRC  = 5;
  localparam int SRC_W = 3;

  // Vertex sources, oldest first; the current vertex comes last.
  localparam logic [SRC_W-1:0] SRC_ANCHOR = 3'd0;
  localparam logic [SRC_W-1:0] SRC_R2     = 3'd1;
  localparam logic [SRC_W-1:0] SRC_R1     = 3'd2;
  localparam logic [SRC_W-1:0] SRC_R0     = 3'd3;
  localparam logic [SRC_W-1:0] SRC_CUR    = 3'd4;

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [1:0]       phase3_r, phase3_nxt;

  logic [COORD_BITS-1:0]         anchor_x_r, anchor_y_r;
  logic [paclip_pkg::CODE_W-1:0] anchor_c_r;
  logic [COORD_BITS-1:0]         rec_x_r [3];
  logic [COORD_BITS-1:0]         rec_y_r [3];
  logic [paclip_pkg::CODE_W-1:0] rec_c_r [3];

  logic [COORD_BITS-1:0]         cur_x, cur_y;
  logic                          in_range;
  logic [paclip_pkg::IDX_W-1:0]  i11;

  logic [COORD_BITS-1:0]         vx [NSRC];
  logic [COORD_BITS-1:0]         vy [NSRC];
  logic [paclip_pkg::CODE_W-1:0] vc [NSRC];
  logic [paclip_pkg::IDX_W-1:0]  vi [NSRC];

  logic [SRC_W-1:0] src [2][3];
  logic [1:0]       prim_on;

  // The raw field bits are read in COORD_BITS bits, then taken as two's complement.
  assign cur_x    = COORD_BITS'($unsigned(screen_x));
  assign cur_y    = COORD_BITS'($unsigned(screen_y));
  assign in_range = (cnt_r < CNT_W'(MAX_VERTICES));
  assign i11      = paclip_pkg::IDX_W'(cnt_r);

  always_comb begin
    vx[SRC_ANCHOR] = anchor_x_r;
    vy[SRC_ANCHOR] = anchor_y_r;
    vc[SRC_ANCHOR] = anchor_c_r;
    vi[SRC_ANCHOR] = '0;
    vx[SRC_R2]     = rec_x_r[2];
    vy[SRC_R2]     = rec_y_r[2];
    vc[SRC_R2]     = rec_c_r[2];
    vi[SRC_R2]     = i11 - paclip_pkg::IDX_W'(3);
    vx[SRC_R1]     = rec_x_r[1];
    vy[SRC_R1]     = rec_y_r[1];
    vc[SRC_R1]     = rec_c_r[1];
    vi[SRC_R1]     = i11 - paclip_pkg::IDX_W'(2);
    vx[SRC_R0]     = rec_x_r[0];
    vy[SRC_R0]     = rec_y_r[0];
    vc[SRC_R0]     = rec_c_r[0];
    vi[SRC_R0]     = i11 - paclip_pkg::IDX_W'(1);
    vx[SRC_CUR]    = cur_x;
    vy[SRC_CUR]    = cur_y;
    vc[SRC_CUR]    = clip_code;
    vi[SRC_CUR]    = i11;
  end

  // Corner selection by primitive kind and position in the batch.
  always_comb begin
    prim_on = 2'b00;
    for (int s = 0; s < 2; s++) begin
      for (int k = 0; k < 3; k++) begin
        src[s][k] = SRC_CUR;
      end
    end
    case (kind)
      paclip_pkg::KIND_TRIANGLES: begin
        prim_on[0] = (phase3_r == 2'd2);
        src[0][0]  = SRC_R1;
        src[0][1]  = SRC_R0;
        src[0][2]  = SRC_CUR;
      end
      paclip_pkg::KIND_FAN: begin
        prim_on[0] = (cnt_r >= CNT_W'(2));
        src[0][0]  = SRC_ANCHOR;
        src[0][1]  = SRC_R0;
        src[0][2]  = SRC_CUR;
      end
      paclip_pkg::KIND_QUADS: begin
        prim_on    = {2{cnt_r[1:0] == 2'b11}};
        src[0][0]  = SRC_R2;
        src[0][1]  = SRC_R1;
        src[0][2]  = SRC_R0;
        src[1][0]  = SRC_R2;
        src[1][1]  = SRC_R0;
        src[1][2]  = SRC_CUR;
      end
      paclip_pkg::KIND_STRIP: begin
        prim_on[0] = (cnt_r >= CNT_W'(2));
        src[0][0]  = SRC_CUR;
        src[0][1]  = cnt_r[0] ? SRC_R1 : SRC_R0;
        src[0][2]  = cnt_r[0] ? SRC_R0 : SRC_R1;
      end
      paclip_pkg::KIND_QUAD_STRIP: begin
        prim_on    = {2{(cnt_r >= CNT_W'(3)) && cnt_r[0]}};
        src[0][0]  = SRC_R2;
        src[0][1]  = SRC_R1;
        src[0][2]  = SRC_R0;
        src[1][0]  = SRC_R1;
        src[1][1]  = SRC_CUR;
        src[1][2]  = SRC_R0;
      end
      default: begin
        prim_on = 2'b00;
      end
    endcase
  end

  // Trivial reject: a shared outcode bit, or any near-plane clipped corner.
  always_comb begin
    logic [paclip_pkg::CODE_W-1:0] c_and, c_or;
    for (int s = 0; s < 2; s++) begin
      c_and = vc[src[s][0]] & vc[src[s][1]] & vc[src[s][2]];
      c_or  = vc[src[s][0]] | vc[src[s][1]] | vc[src[s][2]];
      job.valid[s] = in_range && prim_on[s] && (c_and == '0) && !c_or[paclip_pkg::NEAR_BIT];
      job.prim[s].idx_a      = vi[src[s][0]];
      job.prim[s].idx_b      = vi[src[s][1]];
      job.prim[s].idx_c      = vi[src[s][2]];
      job.prim[s].needs_clip = |c_or[paclip_pkg::XY_CLIP_W-1:0];
      for (int k = 0; k < 3; k++) begin
        job_x[s][k] = vx[src[s][k]];
        job_y[s][k] = vy[src[s][k]];
      end
    end
  end

  always_comb begin
    cnt_nxt    = cnt_r;
    phase3_nxt = phase3_r;
    if (in_range) begin
      cnt_nxt    = cnt_r + 1'b1;
      phase3_nxt = (phase3_r == 2'd2) ? 2'd0 : phase3_r + 2'd1;
    end
    if (batch_end) begin
      cnt_nxt    = '0;
      phase3_nxt = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      phase3_r <= 2'd0;
    end else if (accept) begin
      cnt_r    <= cnt_nxt;
      phase3_r <= phase3_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_range) begin
      if (cnt_r == '0) begin
        anchor_x_r <= cur_x;
        anchor_y_r <= cur_y;
        anchor_c_r <= clip_code;
      end
      rec_x_r[2] <= rec_x_r[1];
      rec_y_r[2] <= rec_y_r[1];
      rec_c_r[2] <= rec_c_r[1];
      rec_x_r[1] <= rec_x_r[0];
      rec_y_r[1] <= rec_y_r[0];
      rec_c_r[1] <= rec_c_r[0];
      rec_x_r[0] <= cur_x;
      rec_y_r[0] <= cur_y;
      rec_c_r[0] <= clip_code;
    end
  end

endmodule

/* rtl/paclip_emitter.sv */
// Job register, signed-area winding check and result register.
// Depends on paclip_pkg.
`timescale 1ns / 1ps

module paclip_emitter #(
  parameter int COORD_BITS = paclip_pkg::DEF_COORD_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              load,
  input  paclip_pkg::job_ctrl_t             job,
  input  logic [1:0][2:0][COORD_BITS-1:0]   job_x,
  input  logic [1:0][2:0][COORD_BITS-1:0]   job_y,
  input  logic                              cull_none,
  input  logic                              out_ready,
  output paclip_pkg::emit_stat_t            stat,
  output logic                              out_valid,
  output logic [paclip_pkg::IDX_W-1:0]      out_first_index,
  output logic [paclip_pkg::IDX_W-1:0]      out_second_index,
  output logic [paclip_pkg::IDX_W-1:0]      out_third_index,
  output logic                              out_needs_clipping,
  output logic                              out_run_last
);

  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;
  localparam int AW = PW + 1;

  logic [1:0]                       job_v_r, job_v_nxt;
  paclip_pkg::prim_ctrl_t [1:0]     job_p_r;
  logic [1:0][2:0][COORD_BITS-1:0]  job_x_r, job_y_r;

  logic                             out_valid_r;
  logic [paclip_pkg::IDX_W-1:0]     first_r, second_r, third_r;
  logic                             clip_r, last_r;

  logic                             sel, out_adv, emit, last;
  paclip_pkg::prim_ctrl_t           cur_p;
  logic signed [DW-1:0]             xa, xb, xc, ya, yb, yc;
  logic signed [DW-1:0]             dx_ac, dy_ab, dx_ab, dy_ac;
  logic signed [PW-1:0]             prod1, prod2;
  logic signed [AW-1:0]             area;
  logic                             swap;

  assign sel     = !job_v_r[0];
  assign out_adv = !out_valid_r || out_ready;
  assign emit    = (|job_v_r) && out_adv;
  assign last    = !(&job_v_r);
  assign cur_p   = job_p_r[sel];

  assign stat.pending = job_v_r;
  assign stat.ready   = !(|job_v_r) || (emit && last);

  // Sign-extend the stored coordinates by one bit so the differences are exact.
  assign xa = {job_x_r[sel][0][COORD_BITS-1], job_x_r[sel][0]};
  assign xb = {job_x_r[sel][1][COORD_BITS-1], job_x_r[sel][1]};
  assign xc = {job_x_r[sel][2][COORD_BITS-1], job_x_r[sel][2]};
  assign ya = {job_y_r[sel][0][COORD_BITS-1], job_y_r[sel][0]};
  assign yb = {job_y_r[sel][1][COORD_BITS-1], job_y_r[sel][1]};
  assign yc = {job_y_r[sel][2][COORD_BITS-1], job_y_r[sel][2]};

  assign dx_ac = xa - xc;
  assign dy_ab = ya - yb;
  assign dx_ab = xa - xb;
  assign dy_ac = ya - yc;
  assign prod1 = PW'(dx_ac) * PW'(dy_ab);
  assign prod2 = PW'(dx_ab) * PW'(dy_ac);
  assign area  = {prod1[PW-1], prod1} - {prod2[PW-1], prod2};

  // With culling off, a triangle of zero or positive area has its first and third corners swapped.
  assign swap = cull_none && !area[AW-1];

  always_comb begin
    job_v_nxt = job_v_r;
    if (emit) begin
      job_v_nxt[sel] = 1'b0;
    end
    if (load) begin
      job_v_nxt = job.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_v_r     <= 2'b00;
      out_valid_r <= 1'b0;
    end else begin
      job_v_r <= job_v_nxt;
      if (out_adv) begin
        out_valid_r <= |job_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      job_p_r <= job.prim;
      job_x_r <= job_x;
      job_y_r <= job_y;
    end
    if (emit) begin
      first_r  <= swap ? cur_p.idx_c : cur_p.idx_a;
      second_r <= cur_p.idx_b;
      third_r  <= swap ? cur_p.idx_a : cur_p.idx_c;
      clip_r   <= cur_p.needs_clip;
      last_r   <= last;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_first_index    = first_r;
  assign out_second_index   = second_r;
  assign out_third_index    = third_r;
  assign out_needs_clipping = clip_r;
  assign out_run_last       = last_r;

endmodule

/* rtl/primitive_assembly_clip_cull_core.sv */
// Top level of the primitive assembly block with trivial reject and winding fix-up.
// Depends on paclip_pkg, paclip_assembler and paclip_emitter.
`timescale 1ns / 1ps

// Usage:
// The input channel takes one projected vertex word per cycle while in_ready is
// high (screen x, screen y, clip outcode, batch end). The block assembles triangles
// for the triangle list, fan, strip, quad and quad strip kinds (the polygon and
// line kinds yield none), drops those trivially outside or near-plane clipped, and
// sends the surviving triangles' corner indices on the output channel, one
// triangle word per cycle while out_ready is high. The last triangle word caused
// by a vertex carries run_last. The vertex is assembled into the job register at
// the accepting edge, and each triangle then moves into the result register once
// that register is free. The block takes one vertex per cycle unless the receiver
// stalls or a vertex yields two surviving triangles (quads, quad strip), which
// hold the job register until the result register has taken both of them.
// When the receiver stalls, the result register holds its word and the job register
// holds the pending triangles; one more vertex is still accepted while it is empty.
// Configuration is written through cfg_write_en, cfg_index and cfg_data and must
// happen while the block is idle. Synchronous reset clears the configuration to a
// triangle list with culling on, restarts the vertex count and empties both the
// job and result registers.

module primitive_assembly_clip_cull_core #(
  parameter int MAX_VERTICES = paclip_pkg::DEF_MAX_VERTICES,
  parameter int COORD_BITS   = paclip_pkg::DEF_COORD_BITS
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  logic signed [paclip_pkg::IN_COORD_W-1:0] in_screen_x,
  input  logic signed [paclip_pkg::IN_COORD_W-1:0] in_screen_y,
  input  logic [paclip_pkg::CODE_W-1:0]            in_clip_code,
  input  logic                                     in_batch_end,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output logic [paclip_pkg::IDX_W-1:0]             out_first_index,
  output logic [paclip_pkg::IDX_W-1:0]             out_second_index,
  output logic [paclip_pkg::IDX_W-1:0]             out_third_index,
  output logic                                     out_needs_clipping,
  output logic                                     out_run_last,
  input  logic                                     cfg_write_en,
  input  logic [paclip_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [paclip_pkg::CFG_DATA_W-1:0]        cfg_data
);

  logic [paclip_pkg::KIND_W-1:0] kind_r;
  logic                          cull_none_r;

  logic                            accept;
  paclip_pkg::job_ctrl_t           job;
  logic [1:0][2:0][COORD_BITS-1:0] job_x, job_y;
  paclip_pkg::emit_stat_t          stat;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r      <= paclip_pkg::KIND_TRIANGLES;
      cull_none_r <= 1'b0;
    end else if (cfg_write_en) begin
      case (cfg_index)
        paclip_pkg::CFG_PRIMITIVE_KIND: kind_r      <= cfg_data;
        paclip_pkg::CFG_CULL_NONE:      cull_none_r <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // A vertex is taken whenever the job register is empty or drains this cycle.
  assign in_ready = stat.ready;
  assign accept   = in_valid && in_ready;

  paclip_assembler #(
    .MAX_VERTICES (MAX_VERTICES),
    .COORD_BITS   (COORD_BITS)
  ) u_assembler (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .screen_x  (in_screen_x),
    .screen_y  (in_screen_y),
    .clip_code (in_clip_code),
    .batch_end (in_batch_end),
    .kind      (kind_r),
    .job       (job),
    .job_x     (job_x),
    .job_y     (job_y)
  );

  paclip_emitter #(
    .COORD_BITS (COORD_BITS)
  ) u_emitter (
    .clk                (clk),
    .rst_n              (rst_n),
    .load               (accept),
    .job                (job),
    .job_x              (job_x),
    .job_y              (job_y),
    .cull_none          (cull_none_r),
    .out_ready          (out_ready),
    .stat               (stat),
    .out_valid          (out_valid),
    .out_first_index    (out_first_index),
    .out_second_index   (out_second_index),
    .out_third_index    (out_third_index),
    .out_needs_clipping (out_needs_clipping),
    .out_run_last       (out_run_last)
  );

  // With two triangles still pending, no new vertex may overwrite the job register.
  a_no_accept_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (stat.pending == 2'b11) |-> !in_ready)
    else $error("vertex accepted while two triangles were pending");

  // A word without run_last must leave its sibling triangle in the job register.
  a_sibling_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_run_last) |-> (stat.pending != 2'b00))
    else $error("non-final triangle word with nothing left pending");

  // A pending triangle moves into an empty result register at the next edge.
  a_drain_to_empty_output: assert property (@(posedge clk) disable iff (!rst_n)
    ((stat.pending != 2'b00) && !out_valid) |=> out_valid)
    else $error("pending triangle not moved into empty result register");

endmodule
